[design/olr_pkg.sv]
// shared types and constants for the polygon outline line rasterizer
`timescale 1ns / 1ps
package olr_pkg;

  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned COORD_BITS   = 9;
  localparam int unsigned IDX_BITS     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNT_BITS     = $clog2(MAX_VERTICES + 1);
  // error term spans about four times the longest axis, signed
  localparam int unsigned ERR_BITS     = COORD_BITS + 3;
  localparam int unsigned LEVEL_BITS   = 8;
  localparam int unsigned COLOUR_BITS  = 3 * LEVEL_BITS;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLOSE = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]            operation;
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [COLOUR_BITS-1:0] pixel_colour;
    logic                   outline_done;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } vtx_t;

  // sequencer to edge stepper
  typedef struct packed {
    logic latch_start;
    logic calc_diff;
    logic calc_setup;
    logic advance;
  } stp_ctrl_t;

  // edge stepper to sequencer
  typedef struct packed {
    logic                  steps_zero;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
  } stp_stat_t;

endpackage

[design/polygon_outline_line_raster.sv]
// Polygon outline rasterizer. Add-vertex transfers store a vertex in the vertex ram and
// return it as a registered pixel in the next cycle. A close transfer reads the first two
// vertices and sets up the first edge through the load, difference and setup states,
// giving no result (with fewer than two vertices it returns the done result at once). Each
// step transfer then returns one outline pixel per cycle in the configured colour unless
// the output stalls. A step that moves on to a new edge runs through the accepting cycle,
// two reads through the single ram read port, a difference state, a setup state and the
// step itself, repeating all but the accepting cycle per zero-length edge skipped. After
// the closing edge the next step returns the done result and the vertex count clears. Adds
// and closes are ignored while an outline is being drawn, adds beyond capacity too.
`timescale 1ns / 1ps
module polygon_outline_line_raster (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [olr_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [olr_pkg::LEVEL_BITS-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  olr_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output olr_pkg::out_item_t                  out_item_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD_A = 6'b000010,
    ST_LOAD_B = 6'b000100,
    ST_DIFF   = 6'b001000,
    ST_SETUP  = 6'b010000,
    ST_STEP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [olr_pkg::LEVEL_BITS-1:0] red_q, green_q, blue_q;
  logic [olr_pkg::CNT_BITS-1:0]   count_q, count_d;
  logic [olr_pkg::IDX_BITS-1:0]   edge_q, edge_d;
  logic                           drawing_q, drawing_d;
  logic                           pend_q, pend_d;
  logic                           out_valid_q, out_valid_d;
  olr_pkg::out_item_t             out_item_q, out_item_d;

  logic                           out_free, in_acc, step_go, last_edge, more_next;
  logic [olr_pkg::CNT_BITS-1:0]   edge_next;
  logic                           ram_we;
  logic [olr_pkg::IDX_BITS-1:0]   ram_waddr, ram_raddr;
  olr_pkg::vtx_t                  ram_wdata, ram_rdata;
  olr_pkg::stp_ctrl_t             stp_ctrl;
  olr_pkg::stp_stat_t             stp_stat;
  logic [olr_pkg::COLOUR_BITS-1:0] colour;

  assign colour     = {red_q, green_q, blue_q};
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign edge_next  = olr_pkg::CNT_BITS'(edge_q) + 1'b1;
  assign last_edge  = edge_next >= count_q;
  assign more_next  = edge_next < count_q;

  // edge end point wraps to vertex zero on the closing edge
  always_comb begin
    ram_raddr = edge_q;
    if (state_q == ST_LOAD_B) begin
      ram_raddr = more_next ? edge_next[olr_pkg::IDX_BITS-1:0] : '0;
    end
  end

  assign step_go = ((state_q == ST_IDLE) && in_acc && drawing_q &&
                    (in_item_i.operation == olr_pkg::OP_STEP)) ||
                   ((state_q == ST_STEP) && out_free);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    edge_d      = edge_q;
    drawing_d   = drawing_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[olr_pkg::IDX_BITS-1:0];
    ram_wdata   = '{x: in_item_i.vertex_x, y: in_item_i.vertex_y};
    stp_ctrl    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item_i.operation)
            olr_pkg::OP_ADD: begin
              if (!drawing_q && (count_q < olr_pkg::CNT_BITS'(olr_pkg::MAX_VERTICES))) begin
                ram_we      = 1'b1;
                count_d     = count_q + 1'b1;
                out_valid_d = 1'b1;
                out_item_d  = '{pixel_x: in_item_i.vertex_x, pixel_y: in_item_i.vertex_y,
                                pixel_colour: colour, outline_done: 1'b0};
              end
            end
            olr_pkg::OP_CLOSE: begin
              if (!drawing_q) begin
                if (count_q < olr_pkg::CNT_BITS'(2)) begin
                  count_d     = '0;
                  out_valid_d = 1'b1;
                  out_item_d  = '{pixel_x: '0, pixel_y: '0, pixel_colour: '0,
                                  outline_done: 1'b1};
                end else begin
                  edge_d    = '0;
                  drawing_d = 1'b1;
                  pend_d    = 1'b0;
                  state_d   = ST_LOAD_A;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD_A: begin
        state_d = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        stp_ctrl.latch_start = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        stp_ctrl.calc_diff = 1'b1;
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        stp_ctrl.calc_setup = 1'b1;
        state_d = pend_q ? ST_STEP : ST_IDLE;
      end
      ST_STEP: begin
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // shared step evaluation, from idle on a step transfer or after an edge load
    if (step_go) begin
      if (!stp_stat.steps_zero) begin
        stp_ctrl.advance = 1'b1;
        out_valid_d = 1'b1;
        out_item_d  = '{pixel_x: stp_stat.cur_x, pixel_y: stp_stat.cur_y,
                        pixel_colour: colour, outline_done: 1'b0};
        state_d     = ST_IDLE;
      end else if (last_edge) begin
        drawing_d   = 1'b0;
        count_d     = '0;
        out_valid_d = 1'b1;
        out_item_d  = '{pixel_x: '0, pixel_y: '0, pixel_colour: '0, outline_done: 1'b1};
        state_d     = ST_IDLE;
      end else begin
        edge_d  = edge_next[olr_pkg::IDX_BITS-1:0];
        pend_d  = 1'b1;
        state_d = ST_LOAD_A;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      edge_q      <= '0;
      drawing_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      edge_q      <= edge_d;
      drawing_q   <= drawing_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          olr_pkg::REG_RED:   red_q   <= cfg_wdata_i;
          olr_pkg::REG_GREEN: green_q <= cfg_wdata_i;
          olr_pkg::REG_BLUE:  blue_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  olr_ram #(
    .WIDTH(2 * olr_pkg::COORD_BITS),
    .DEPTH(olr_pkg::MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  olr_stepper u_stepper (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(stp_ctrl),
    .vtx_i (ram_rdata),
    .stat_o(stp_stat)
  );

  // vertex count never runs past capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olr_pkg::CNT_BITS'(olr_pkg::MAX_VERTICES))
    else $error("vertex count beyond capacity");

  // an outline is only drawn with at least two vertices
  a_draw_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drawing_q |-> (count_q >= olr_pkg::CNT_BITS'(2)))
    else $error("drawing with fewer than two vertices");

  // the vertex ram is never written while edges are being read from it
  a_no_write_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !drawing_q)
    else $error("vertex write during outline");

  // edge load and step states only run while drawing
  a_busy_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> drawing_q)
    else $error("sequencer busy without an outline");

endmodule

[design/olr_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module olr_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/olr_stepper.sv]
// bresenham edge setup and per-pixel stepping registers
`timescale 1ns / 1ps
module olr_stepper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  olr_pkg::stp_ctrl_t  ctrl_i,
  input  olr_pkg::vtx_t       vtx_i,
  output olr_pkg::stp_stat_t  stat_o
);

  logic [olr_pkg::COORD_BITS-1:0] cur_x_q, cur_y_q, cur_x_d, cur_y_d;
  logic [olr_pkg::COORD_BITS-1:0] dx_q, dy_q, dx_d, dy_d;
  logic [1:0]                     xdir_q, ydir_q, xdir_d, ydir_d;
  logic                           swap_q, swap_d;
  logic [olr_pkg::COORD_BITS-1:0] steps_q, steps_d;
  logic signed [olr_pkg::ERR_BITS-1:0] err_q, err_d;
  logic signed [olr_pkg::ERR_BITS-1:0] diag_q, diag_d;
  logic signed [olr_pkg::ERR_BITS-1:0] strt_q, strt_d;

  logic [olr_pkg::COORD_BITS-1:0] maj, mnr;
  logic signed [olr_pkg::ERR_BITS-1:0] maj_e, mnr2;
  logic                           err_pos, x_move, y_move;
  logic [olr_pkg::COORD_BITS-1:0] x_inc, y_inc;

  // absolute differences and step directions against the latched start point
  always_comb begin
    if (vtx_i.x > cur_x_q) begin
      dx_d   = vtx_i.x - cur_x_q;
      xdir_d = 2'b01;
    end else begin
      dx_d   = cur_x_q - vtx_i.x;
      xdir_d = (vtx_i.x < cur_x_q) ? 2'b11 : 2'b00;
    end
    if (vtx_i.y > cur_y_q) begin
      dy_d   = vtx_i.y - cur_y_q;
      ydir_d = 2'b01;
    end else begin
      dy_d   = cur_y_q - vtx_i.y;
      ydir_d = (vtx_i.y < cur_y_q) ? 2'b11 : 2'b00;
    end
  end

  // major and minor axis, initial error and both error increments
  always_comb begin
    swap_d = dy_q > dx_q;
    maj    = swap_d ? dy_q : dx_q;
    mnr    = swap_d ? dx_q : dy_q;
    maj_e  = $signed(olr_pkg::ERR_BITS'(maj));
    mnr2   = $signed(olr_pkg::ERR_BITS'(mnr) << 1);
    err_d  = mnr2 - maj_e;
    diag_d = mnr2 - (maj_e <<< 1);
    strt_d = mnr2;
  end

  assign err_pos = !err_q[olr_pkg::ERR_BITS-1] && (err_q != '0);
  assign x_move  = swap_q ? err_pos : 1'b1;
  assign y_move  = swap_q ? 1'b1 : err_pos;
  assign x_inc   = {{(olr_pkg::COORD_BITS-2){xdir_q[1]}}, xdir_q};
  assign y_inc   = {{(olr_pkg::COORD_BITS-2){ydir_q[1]}}, ydir_q};

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    steps_d = steps_q;
    if (ctrl_i.latch_start) begin
      cur_x_d = vtx_i.x;
      cur_y_d = vtx_i.y;
    end else if (ctrl_i.advance) begin
      if (x_move) begin
        cur_x_d = cur_x_q + x_inc;
      end
      if (y_move) begin
        cur_y_d = cur_y_q + y_inc;
      end
      steps_d = steps_q - 1'b1;
    end
    if (ctrl_i.calc_setup) begin
      steps_d = maj;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else begin
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    if (ctrl_i.calc_diff) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      xdir_q <= xdir_d;
      ydir_q <= ydir_d;
    end
    if (ctrl_i.calc_setup) begin
      swap_q <= swap_d;
      err_q  <= err_d;
      diag_q <= diag_d;
      strt_q <= strt_d;
    end else if (ctrl_i.advance) begin
      err_q <= err_q + (err_pos ? diag_q : strt_q);
    end
  end

  assign stat_o.steps_zero = (steps_q == '0);
  assign stat_o.cur_x      = cur_x_q;
  assign stat_o.cur_y      = cur_y_q;

endmodule
